// ----- hdl/fat12_pkg.sv -----
// FAT12 cluster table engine: shared types and constants.
// No dependencies.
package fat12_pkg;
  localparam int TableDepth = 4096;
  localparam int IdxW = $clog2(TableDepth);
  localparam int StampW = 8;
  localparam logic [11:0] ChainEnd = 12'hFFF;
  localparam logic [11:0] MarkLow = 12'hFF8;
  localparam logic [11:0] LastData = 12'hFF6;
  localparam logic RegTotalClusters = 1'b0;

  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_ALLOC = 2'd2,
    KIND_FREE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [11:0] cluster;
    logic [11:0] value;
    logic [11:0] count;
    logic bad_index;
    logic [11:0] top;
  } cmd_t;
endpackage

// ----- hdl/fat12_cluster_table_engine.sv -----
// FAT12 cluster table engine top level: config port, front end and back end.
// Depends on fat12_pkg, fat12_front, fat12_back.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------
//  request | in_valid  | in_stall  | kind, cluster, value, count
//  result  | out_valid | out_stall | status, result_value
//  config  | APB psel/penable/pwrite, paddr, pwdata, prdata, pready
//
// In the back end a read steps through issue, data and result, and a write goes
// straight to its result; allocate reads each scanned cluster from memory and
// then links it; free reads, checks and clears each chain link. The worst case
// is one failed allocate: a scan of up to 4085 clusters plus the unwind.
// After reset the back end sweeps the table and visit stamps to zero before
// the first request is taken; every 255 requests it sweeps the visit stamps
// again. A two-entry queue decouples intake.
module fat12_cluster_table_engine (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] kind,
  input  logic [11:0] cluster,
  input  logic [11:0] value,
  input  logic [11:0] count,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [11:0] result_value,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import fat12_pkg::*;

  logic [11:0] total_clusters;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  assign pready = 1'b1;
  assign prdata = {20'd0, total_clusters};

  // hold register until an access-phase write lands
  always_ff @(posedge clk) begin
    if (rst) total_clusters <= 12'd0;
    else if (psel && penable && pwrite && paddr == RegTotalClusters)
      total_clusters <= pwdata[11:0];
  end

  fat12_front u_front (
    .clk, .rst, .in_valid, .in_stall, .kind, .cluster, .value, .count,
    .total_clusters, .q_valid, .q_pop, .q_cmd
  );

  fat12_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_cmd, .out_valid, .out_stall,
    .status, .result_value
  );

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3) else $error("bad status");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value))
    else $error("result dropped");
  a_nospace_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> result_value == 12'd0)
    else $error("nonzero result on error");
endmodule

// ----- hdl/fat12_front.sv -----
// FAT12 front end: accepts requests, classifies them, two-entry command queue.
// Depends on fat12_pkg.
module fat12_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] kind,
  input  logic [11:0] cluster,
  input  logic [11:0] value,
  input  logic [11:0] count,
  input  logic [11:0] total_clusters,
  output logic q_valid,
  input  logic q_pop,
  output fat12_pkg::cmd_t q_cmd
);
  import fat12_pkg::*;

  cmd_t slot [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] fill;
  cmd_t cmd_in;
  logic [12:0] top_w;
  logic push;

  always_comb begin
    top_w = {1'b0, total_clusters} + 13'd1;
    if (top_w > {1'b0, LastData}) top_w = {1'b0, LastData};
    if (top_w > 13'(TableDepth - 1)) top_w = 13'(TableDepth - 1);
    cmd_in.kind = kind;
    cmd_in.cluster = cluster;
    cmd_in.value = value;
    cmd_in.count = count;
    cmd_in.bad_index = {1'b0, cluster} >= 13'(TableDepth);
    cmd_in.top = top_w[11:0];
  end

  assign in_stall = fill == 2'd2;
  assign push = in_valid && !in_stall;
  assign q_valid = fill != 2'd0;
  assign q_cmd = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= cmd_in;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ----- hdl/fat12_back.sv -----
// FAT12 back end: link table memory, sequencer for read/write/alloc/free.
// Depends on fat12_pkg.
module fat12_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  fat12_pkg::cmd_t q_cmd,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [11:0] result_value
);
  import fat12_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_SWEEP, S_IDLE, S_RD, S_AL_RD, S_AL_CHK, S_AL_DONE,
    S_FR_START, S_FR_RD, S_FR_CHK, S_OUT
  } state_t;

  state_t state;
  logic [11:0] mem [TableDepth];
  logic [11:0] rdata;
  logic [IdxW-1:0] raddr;
  logic re, we;
  logic [IdxW-1:0] waddr;
  logic [11:0] wdata;
  logic [StampW-1:0] stamp [TableDepth];
  logic [StampW-1:0] stamp_rd;
  logic [StampW-1:0] stamp_wdata;
  logic stamp_we;
  logic [StampW-1:0] epoch;
  logic [11:0] c, first, prev, got;
  logic alloc_fail;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // Visit stamps: an entry belongs to the current walk when its stamp equals epoch.
  always_ff @(posedge clk) begin
    if (stamp_we) stamp[c[IdxW-1:0]] <= stamp_wdata;
    if (re) stamp_rd <= stamp[raddr];
  end

  assign out_valid = state == S_OUT;

  always_comb begin
    re = 1'b0; raddr = c[IdxW-1:0]; we = 1'b0; waddr = c[IdxW-1:0];
    wdata = 12'd0; q_pop = 1'b0; stamp_we = 1'b0; stamp_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1; stamp_we = 1'b1;
      end
      S_SWEEP: stamp_we = 1'b1;
      S_IDLE: begin
        q_pop = q_valid;
        raddr = q_cmd.cluster[IdxW-1:0];
        re = q_valid;
        if (q_valid && q_cmd.kind == KIND_WRITE && !q_cmd.bad_index) begin
          we = 1'b1; waddr = q_cmd.cluster[IdxW-1:0]; wdata = q_cmd.value;
        end
      end
      S_AL_RD: re = 1'b1;
      S_AL_CHK: begin
        if (rdata == 12'd0 && prev != 12'd0) begin
          we = 1'b1; waddr = prev[IdxW-1:0]; wdata = c;
        end
      end
      S_AL_DONE: begin
        if (!alloc_fail) begin
          we = 1'b1; waddr = prev[IdxW-1:0]; wdata = ChainEnd;
        end
      end
      S_FR_RD: re = 1'b1;
      S_FR_CHK: begin
        if (stamp_rd != epoch) begin
          we = 1'b1; stamp_we = 1'b1; stamp_wdata = epoch;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      c <= 12'd0;
      epoch <= StampW'(1);
    end else begin
      unique case (state)
        S_CLEAR: begin
          // zero the table and the visit stamps
          c <= c + 12'd1;
          if (c == 12'(TableDepth - 1)) state <= S_IDLE;
        end
        S_SWEEP: begin
          // zero the visit stamps once the epoch has run out
          c <= c + 12'd1;
          if (c == 12'(TableDepth - 1)) begin
            epoch <= StampW'(1);
            state <= S_IDLE;
          end
        end
        S_IDLE: if (q_valid) begin
          cmd <= q_cmd;
          status <= ST_OK;
          result_value <= 12'd0;
          unique case (kind_t'(q_cmd.kind))
            KIND_READ: state <= q_cmd.bad_index ? S_OUT : S_RD;
            KIND_WRITE: state <= S_OUT;
            KIND_ALLOC: begin
              c <= 12'd2; first <= 12'd0; prev <= 12'd0; got <= 12'd0;
              state <= (q_cmd.count == 12'd0) ? S_OUT :
                       (q_cmd.top < 12'd2) ? S_AL_DONE : S_AL_RD;
            end
            KIND_FREE: begin
              c <= q_cmd.cluster;
              state <= S_FR_START;
            end
          endcase
          if (q_cmd.bad_index && (q_cmd.kind == KIND_READ || q_cmd.kind == KIND_WRITE))
            status <= ST_ERROR;
        end
        S_RD: begin
          result_value <= rdata;
          state <= S_OUT;
        end
        S_AL_RD: state <= S_AL_CHK;
        S_AL_CHK: begin
          if (rdata == 12'd0) begin
            if (prev == 12'd0) first <= c;
            prev <= c;
            got <= got + 12'd1;
          end
          if ((rdata == 12'd0 && got + 12'd1 == cmd.count) || c == cmd.top)
            state <= S_AL_DONE;
          else begin
            c <= c + 12'd1;
            state <= S_AL_RD;
          end
        end
        S_AL_DONE: begin
          if (alloc_fail) begin
            status <= ST_NOSPACE;
            c <= first;
            state <= S_FR_START;
          end else begin
            result_value <= first;
            state <= S_OUT;
          end
        end
        S_FR_START: begin
          if (c < 12'd2 || c >= MarkLow) state <= S_OUT;
          else if ({1'b0, c} >= 13'(TableDepth)) begin
            status <= ST_ERROR; state <= S_OUT;
          end else state <= S_FR_RD;
        end
        S_FR_RD: state <= S_FR_CHK;
        S_FR_CHK: begin
          if (stamp_rd == epoch) begin
            if (status == ST_OK) status <= ST_ERROR;
            state <= S_OUT;
          end else begin
            c <= rdata;
            state <= S_FR_START;
          end
        end
        S_OUT: if (!out_stall) begin
          if (epoch == '1) begin
            c <= 12'd0;
            state <= S_SWEEP;
          end else begin
            epoch <= epoch + StampW'(1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign alloc_fail = got < cmd.count;
endmodule
